### hw/rtl/wud_pkg.sv
package wud_pkg;

  // Width of every payload field word on the operand and result channels
  localparam int unsigned FIELD_BITS = 64;

  // Default geometry
  localparam int unsigned DEF_OPERAND_BITS = 256;
  localparam int unsigned DEF_WORD_BITS    = 64;

  // Status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_DIV_ZERO = 1'b1;

  // Divide unit report to the sequencer
  typedef struct packed {
    logic done;      // one-cycle pulse, results valid
    logic div_zero;  // divisor was zero, results forced to zero
  } wud_div_stat_t;

endpackage

### hw/rtl/wud_if.sv
interface wud_in_if;
  logic                                valid;
  logic                                ready;
  logic [wud_pkg::FIELD_BITS-1:0]      dividend_word;
  logic [wud_pkg::FIELD_BITS-1:0]      divisor_word;
  logic                                operand_last;

  modport source (output valid, dividend_word, divisor_word, operand_last, input ready);
  modport sink   (input valid, dividend_word, divisor_word, operand_last, output ready);
endinterface

interface wud_out_if;
  logic                                valid;
  logic                                ready;
  logic [wud_pkg::FIELD_BITS-1:0]      quotient_word;
  logic [wud_pkg::FIELD_BITS-1:0]      remainder_word;
  logic                                status;
  logic                                result_last;

  modport source (output valid, quotient_word, remainder_word, status, result_last,
                  input ready);
  modport sink   (input valid, quotient_word, remainder_word, status, result_last,
                  output ready);
endinterface

### hw/rtl/wud_div_unit.sv
// Restoring shift/subtract divider, one quotient bit per cycle.
module wud_div_unit #(
  parameter int unsigned OPERAND_BITS = wud_pkg::DEF_OPERAND_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [OPERAND_BITS-1:0]     dividend,
  input  logic [OPERAND_BITS-1:0]     divisor,
  output logic [OPERAND_BITS-1:0]     quotient,
  output logic [OPERAND_BITS-1:0]     remainder,
  output wud_pkg::wud_div_stat_t      stat
);

  localparam int unsigned CNT_W = $clog2(OPERAND_BITS + 1);

  logic                    busy;
  logic                    done;
  logic                    div_zero;
  logic [CNT_W-1:0]        cnt;
  logic [OPERAND_BITS-1:0] rem;
  logic [OPERAND_BITS-1:0] dq;   // dividend bits out at top, quotient bits in at bottom

  logic [OPERAND_BITS:0]   shifted;
  logic [OPERAND_BITS:0]   diff;
  logic                    take;
  logic [OPERAND_BITS-1:0] rem_next;
  logic [OPERAND_BITS-1:0] dq_next;

  // Single wide subtract; no borrow out means the trial fits
  always_comb begin
    shifted  = {rem, dq[OPERAND_BITS-1]};
    diff     = shifted - {1'b0, divisor};
    take     = ~diff[OPERAND_BITS];
    rem_next = take ? diff[OPERAND_BITS-1:0] : shifted[OPERAND_BITS-1:0];
    dq_next  = {dq[OPERAND_BITS-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (divisor == '0) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= CNT_W'(OPERAND_BITS);
        end
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_zero <= (divisor == '0);
      rem      <= '0;
      dq       <= (divisor == '0) ? '0 : dividend;
    end else if (busy) begin
      rem <= rem_next;
      dq  <= dq_next;
    end
  end

  assign quotient      = dq;
  assign remainder     = rem;
  assign stat.done     = done;
  assign stat.div_zero = div_zero;

endmodule

### hw/rtl/wide_unsigned_divider_core.sv
// Channel  | Dir | Payload                                        | Notes
// operand  | in  | dividend_word, divisor_word, operand_last      | LS word first
// result   | out | quotient_word, remainder_word, status, last    | LS word first
//
// Operand words are taken one per cycle while loading; the last word starts the
// subtractor loop in the cycle after it (via start_q), one quotient bit per cycle,
// and a zero divisor skips the loop. OPERAND_BITS/WORD_BITS result words then follow
// at one per cycle while result is ready.
// Reset (rst, sync, active high) returns to word loading at word zero.
// operand is only ready while loading; result stalls simply hold the current word.
module wide_unsigned_divider_core #(
  parameter int unsigned OPERAND_BITS = wud_pkg::DEF_OPERAND_BITS,
  parameter int unsigned WORD_BITS    = wud_pkg::DEF_WORD_BITS
) (
  input logic         clk,
  input logic         rst,
  wud_in_if.sink      operand,
  wud_out_if.source   result
);

  localparam int unsigned NWORDS = OPERAND_BITS / WORD_BITS;
  localparam int unsigned IDX_W  = (NWORDS > 1) ? $clog2(NWORDS) : 1;

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_DIV  = 3'b010,
    ST_SEND = 3'b100
  } state_t;

  state_t                  state;
  state_t                  state_next;

  logic [IDX_W-1:0]        word_idx;   // next operand word position
  logic [IDX_W-1:0]        out_idx;    // result word being sent
  logic [OPERAND_BITS-1:0] dividend_store;
  logic [OPERAND_BITS-1:0] divisor_store;

  logic                    in_fire;
  logic                    out_fire;
  logic                    start;
  logic                    start_q;    // stores hold the last word from here on
  logic                    in_wrap;
  logic                    out_end;

  logic [OPERAND_BITS-1:0] quotient;
  logic [OPERAND_BITS-1:0] remainder;
  wud_pkg::wud_div_stat_t  stat;
  logic                    status_q;

  logic [wud_pkg::FIELD_BITS-1:0] q_word;
  logic [wud_pkg::FIELD_BITS-1:0] r_word;

  assign operand.ready = (state == ST_LOAD);
  assign in_fire       = operand.valid & operand.ready;
  assign start         = in_fire & operand.operand_last;
  assign in_wrap       = (word_idx == IDX_W'(NWORDS - 1));

  assign result.valid  = (state == ST_SEND);
  assign out_fire      = result.valid & result.ready;
  assign out_end       = (out_idx == IDX_W'(NWORDS - 1));

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (start) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (stat.done) state_next = ST_SEND;
      end
      ST_SEND: begin
        if (out_fire && out_end) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      word_idx <= '0;
      out_idx  <= '0;
      start_q  <= 1'b0;
    end else begin
      state   <= state_next;
      start_q <= start;
      if (in_fire) begin
        // last word always rewinds; otherwise advance and wrap
        if (operand.operand_last || in_wrap) word_idx <= '0;
        else                                 word_idx <= word_idx + 1'b1;
      end
      if (stat.done) begin
        out_idx <= '0;
      end else if (out_fire) begin
        out_idx <= out_end ? '0 : out_idx + 1'b1;
      end
    end
  end

  // Operand stores: word written at its slot, upper field bits dropped
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int k = 0; k < NWORDS; k++) begin
        if (word_idx == IDX_W'(k)) begin
          dividend_store[k*WORD_BITS +: WORD_BITS] <= operand.dividend_word[WORD_BITS-1:0];
          divisor_store[k*WORD_BITS +: WORD_BITS]  <= operand.divisor_word[WORD_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) status_q <= stat.div_zero ? wud_pkg::STATUS_DIV_ZERO
                                             : wud_pkg::STATUS_OK;
  end

  wud_div_unit #(
    .OPERAND_BITS (OPERAND_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (start_q),
    .dividend  (dividend_store),
    .divisor   (divisor_store),
    .quotient  (quotient),
    .remainder (remainder),
    .stat      (stat)
  );

  // Result word select, zero-extended to the field width
  always_comb begin
    q_word = '0;
    r_word = '0;
    for (int k = 0; k < NWORDS; k++) begin
      if (out_idx == IDX_W'(k)) begin
        q_word[WORD_BITS-1:0] = quotient[k*WORD_BITS +: WORD_BITS];
        r_word[WORD_BITS-1:0] = remainder[k*WORD_BITS +: WORD_BITS];
      end
    end
  end

  assign result.quotient_word  = q_word;
  assign result.remainder_word = r_word;
  assign result.status         = status_q;
  assign result.result_last    = out_end;

endmodule

### dv/wud_result_checker.sv
`timescale 1ns / 1ps

// Watches both channels, predicts the quotient/remainder words for each
// division request and compares the returned words in order.
module wud_result_checker (
  input  logic clk,
  input  logic rst,
  wud_in_if    operand,
  wud_out_if   result,
  output int   fail_count,
  output int   outstanding
);

  localparam int unsigned OB = wud_pkg::DEF_OPERAND_BITS;
  localparam int unsigned WB = wud_pkg::DEF_WORD_BITS;
  localparam int unsigned NW = OB / WB;
  localparam int unsigned FB = wud_pkg::FIELD_BITS;

  typedef struct {
    logic [FB-1:0] quo;
    logic [FB-1:0] rem;
    logic          status;
    logic          last;
  } qr_word_t;

  // operand words as loaded so far; position wraps like the block's counter
  bit [OB-1:0] dividend_acc;
  bit [OB-1:0] divisor_acc;
  int unsigned word_pos;
  qr_word_t    qr_words[$];

  initial begin
    fail_count   = 0;
    outstanding  = 0;
    dividend_acc = '0;
    divisor_acc  = '0;
    word_pos     = 0;
  end

  // plain restoring division, one quotient bit per pass
  function automatic void restoring_divide(input bit [OB-1:0] num, input bit [OB-1:0] den,
                                           output bit [OB-1:0] quo, output bit [OB-1:0] rem);
    bit [OB:0] part;
    int        i;
    part = '0;
    quo  = '0;
    for (i = OB - 1; i >= 0; i--) begin
      part = {part[OB-1:0], num[i]};
      if (part >= {1'b0, den}) begin
        part   = part - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    rem = part[OB-1:0];
  endfunction

  function automatic int field_differs(string name, logic [FB-1:0] want,
                                       logic [FB-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic take_request();
    bit [OB-1:0] quo;
    bit [OB-1:0] rem;
    logic        status;
    qr_word_t    w;
    int unsigned k;
    dividend_acc[word_pos*WB +: WB] = operand.dividend_word[WB-1:0];
    divisor_acc[word_pos*WB +: WB]  = operand.divisor_word[WB-1:0];
    if (operand.operand_last !== 1'b1) begin
      word_pos = (word_pos == NW - 1) ? 0 : word_pos + 1;
      return;
    end
    word_pos = 0;
    if (divisor_acc == '0) begin
      quo    = '0;
      rem    = '0;
      status = wud_pkg::STATUS_DIV_ZERO;
    end else begin
      restoring_divide(dividend_acc, divisor_acc, quo, rem);
      status = wud_pkg::STATUS_OK;
    end
    for (k = 0; k < NW; k++) begin
      w.quo    = '0;
      w.rem    = '0;
      w.quo[WB-1:0] = quo[k*WB +: WB];
      w.rem[WB-1:0] = rem[k*WB +: WB];
      w.status = status;
      w.last   = (k == NW - 1);
      qr_words.push_back(w);
    end
  endtask

  task automatic check_word();
    qr_word_t want;
    int       bad;
    if (qr_words.size() == 0) begin
      $error("result word with no request outstanding: quotient %h remainder %h",
             result.quotient_word, result.remainder_word);
      fail_count++;
      return;
    end
    want = qr_words.pop_front();
    bad  = field_differs("quotient_word", want.quo, result.quotient_word);
    bad += field_differs("remainder_word", want.rem, result.remainder_word);
    bad += field_differs("status", FB'(want.status), FB'(result.status));
    bad += field_differs("result_last", FB'(want.last), FB'(result.result_last));
    if (bad != 0) fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (result.valid && result.ready) check_word();
      if (operand.valid && operand.ready) take_request();
      outstanding = qr_words.size();
    end
  end

endmodule

### dv/wide_unsigned_divider_core_test.sv
`timescale 1ns / 1ps

// Top of the divider bench: clock, reset, operand requests, result back
// pressure, watchdog and verdict. Prediction and comparison live in the
// checker instance.
module wide_unsigned_divider_core_test;

  localparam int unsigned OB = wud_pkg::DEF_OPERAND_BITS;
  localparam int unsigned WB = wud_pkg::DEF_WORD_BITS;
  localparam int unsigned NW = OB / WB;
  localparam int unsigned FB = wud_pkg::FIELD_BITS;

  // Idle limit: the longest quiet stretch in a good run is the bit-serial
  // loop or a long receiver stall; this is several times both.
  localparam int unsigned IDLE_LIMIT = 2000;
  // Settle time after the last expected word: one full division plus margin.
  localparam int unsigned DRAIN_CYCLES = OB + 64;
  localparam int unsigned RANDOM_REQUESTS = 320;

  logic clk;
  logic rst;
  int   fail_count;
  int   outstanding;

  wud_in_if  operand_ch ();
  wud_out_if result_ch ();

  wide_unsigned_divider_core #(
    .OPERAND_BITS (OB),
    .WORD_BITS    (WB)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .operand (operand_ch),
    .result  (result_ch)
  );

  wud_result_checker qr_check (
    .clk         (clk),
    .rst         (rst),
    .operand     (operand_ch),
    .result      (result_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ---------------------------------------------------------------------
  // Watchdog: any accepted request on either channel resets the count.
  // ---------------------------------------------------------------------
  int unsigned idle_cycles;
  initial idle_cycles = 0;

  always @(posedge clk) begin
    if ((operand_ch.valid && operand_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Result back pressure. The receiver switches between its own modes for
  // random stretches: always ready, mostly ready, rarely ready, and a
  // strict alternating pattern.
  // ---------------------------------------------------------------------
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned tick;
    result_ch.ready = 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 300);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          0: begin
            result_ch.ready = 1'b1;
          end
          1: begin
            result_ch.ready = ($urandom_range(0, 3) != 0);
          end
          2: begin
            result_ch.ready = ($urandom_range(0, 7) == 0);
          end
          default: begin
            result_ch.ready = tick[0];
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Operand request driver. Requests go out in bursts; between bursts valid
  // drops for a random gap (sometimes none at all). Inputs change on the
  // falling edge, acceptance is seen at the rising edge.
  // ---------------------------------------------------------------------
  int unsigned burst_left;
  int unsigned requests_sent;

  task automatic send_request(input logic [FB-1:0] dvd_w,
                              input logic [FB-1:0] dvs_w, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap != 0) begin
        @(negedge clk);
        operand_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    @(negedge clk);
    operand_ch.valid         = 1'b1;
    operand_ch.dividend_word = dvd_w;
    operand_ch.divisor_word  = dvs_w;
    operand_ch.operand_last  = last;
    do @(posedge clk); while (operand_ch.ready !== 1'b1);
    burst_left--;
    requests_sent++;
  endtask

  // Sends count words, operand_last on the final one. Count NW is a normal
  // division; fewer words is an early last (stores keep older words), more
  // words wraps the word position and overwrites earlier words with fresh
  // random data.
  task automatic send_division(input bit [OB-1:0] dvd, input bit [OB-1:0] dvs,
                               input int unsigned count);
    int unsigned w;
    for (w = 0; w < count; w++) begin
      if (w < NW) begin
        send_request(FB'(dvd[w*WB +: WB]), FB'(dvs[w*WB +: WB]),
                     w == count - 1);
      end else begin
        send_request({$urandom, $urandom}, {$urandom, $urandom}, w == count - 1);
      end
    end
  endtask

  function automatic bit [WB-1:0] random_word();
    bit [WB-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = '1;
      2:       v = WB'($urandom_range(0, 15));
      3:       v = WB'(1) << $urandom_range(0, WB - 1);
      default: v = WB'({$urandom, $urandom});
    endcase
    return v;
  endfunction

  // Wide value with a random number of populated low words, so quotients
  // range from tiny to full width.
  function automatic bit [OB-1:0] random_operand();
    bit [OB-1:0] v;
    int unsigned used;
    int unsigned w;
    v    = '0;
    used = ($urandom_range(0, 2) == 0) ? $urandom_range(0, NW) : NW;
    for (w = 0; w < used; w++) v[w*WB +: WB] = random_word();
    return v;
  endfunction

  task automatic send_random_division();
    bit [OB-1:0] dvd;
    bit [OB-1:0] dvs;
    bit [OB-1:0] tmp;
    dvd = random_operand();
    dvs = random_operand();
    case ($urandom_range(0, 15))
      0: dvs = '0;                                   // divide by zero
      1: dvs = dvd;                                  // quotient one or zero divisor
      2, 3: begin                                    // dividend at or below divisor
        if (dvd > dvs) begin
          tmp = dvd;
          dvd = dvs;
          dvs = tmp;
        end
      end
      4, 5: begin                                    // quotient near a power of two
        dvs = dvd >> $urandom_range(1, OB - 1);
        if (dvs == '0) dvs = OB'(1);
      end
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0:       send_division(dvd, dvs, $urandom_range(1, NW - 1));
      1:       send_division(dvd, dvs, $urandom_range(NW + 1, 2 * NW));
      default: send_division(dvd, dvs, NW);
    endcase
  endtask

  initial begin
    rst                      = 1'b1;
    operand_ch.valid         = 1'b0;
    operand_ch.dividend_word = '0;
    operand_ch.divisor_word  = '0;
    operand_ch.operand_last  = 1'b0;
    burst_left               = 0;
    requests_sent            = 0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Directed: extremes and each shortcut path. Every full division here
    // writes all store words, so early-last requests later read known data.
    send_division('1, OB'(1), NW);                       // max / 1
    send_division('0, '1, NW);                           // zero dividend
    send_division(OB'(12345), {1'b1, {(OB-1){1'b0}}}, NW); // dividend below divisor
    send_division('1, '0, NW);                           // zero divisor flagged
    send_division('1, '1, NW);                           // equal operands
    send_division('1, {1'b1, {(OB-1){1'b0}}}, NW);       // divisor top bit only

    // Random: mostly well-formed four-word divisions, some early-last and
    // wrapped sequences mixed in.
    while (requests_sent < RANDOM_REQUESTS) send_random_division();

    @(negedge clk);
    operand_ch.valid        = 1'b0;
    operand_ch.operand_last = 1'b0;

    // drain: watchdog covers a hang here
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/wud_pkg.sv
hw/rtl/wud_if.sv
hw/rtl/wud_div_unit.sv
hw/rtl/wide_unsigned_divider_core.sv
dv/wud_result_checker.sv
dv/wide_unsigned_divider_core_test.sv
